/* sv/tlfa_pkg.sv */
// ----------------------------------------------------------------------------
// tlfa_pkg - shared types and constants for the timed lowest-free allocator
// Transfer payloads, the wave record passed along the cell chain, and sizing.
// ----------------------------------------------------------------------------
package tlfa_pkg;

	localparam int MAX_UNITS = 128;
	localparam int IDX_W     = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
	localparam int CNT_W     = $clog2(MAX_UNITS + 1);
	localparam int TIME_W    = 33;
	localparam int SUM_W     = 14;

	typedef struct packed {
		logic [31:0] arrival_time;
		logic [7:0]  units_wanted;
		logic [15:0] hold_time;
	} in_t;

	typedef struct packed {
		logic             granted;
		logic [SUM_W-1:0] index_sum;
	} out_t;

	// one token moving down the chain; cnt is the free count on the counting
	// pass and the units still to hand out on the grant pass
	typedef struct packed {
		logic             valid;
		logic             grant;
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum;
	} wave_t;

endpackage

/* sv/tlfa_cell.sv */
// ----------------------------------------------------------------------------
// tlfa_cell - one allocation unit of the chain
// Holds the unit's release time, adds itself to a passing count or grants
// itself to a passing request, and registers the token for its neighbour.
// ----------------------------------------------------------------------------
module tlfa_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tlfa_pkg::IDX_W-1:0]  cell_idx,
	input  logic [31:0]                 now,
	input  logic [tlfa_pkg::TIME_W-1:0] expiry,
	input  logic [tlfa_pkg::CNT_W-1:0]  used,
	input  tlfa_pkg::wave_t             wave_in,
	output tlfa_pkg::wave_t             wave_out
);
	import tlfa_pkg::*;

	logic [TIME_W-1:0] rt_q;
	logic              valid_q;
	logic              grant_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic              free;
	logic              take;

	// free when released at or before now; units past the count never join
	always_comb begin
		free = (rt_q <= {1'b0, now}) && (CNT_W'(cell_idx) < used);
		take = wave_in.grant && free && (wave_in.cnt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= wave_in.valid;
			if (wave_in.valid && take)
				rt_q <= expiry;
		end
	end

	always_ff @(posedge clk) begin
		grant_q <= wave_in.grant;
		if (!wave_in.grant) begin
			cnt_q <= wave_in.cnt + CNT_W'(free);
			sum_q <= wave_in.sum;
		end else if (take) begin
			cnt_q <= wave_in.cnt - CNT_W'(1);
			sum_q <= wave_in.sum + SUM_W'(cell_idx) + SUM_W'(1);
		end else begin
			cnt_q <= wave_in.cnt;
			sum_q <= wave_in.sum;
		end
	end

	assign wave_out = '{valid: valid_q, grant: grant_q, cnt: cnt_q, sum: sum_q};

endmodule

/* sv/timed_lowest_free_allocator.sv */
// ----------------------------------------------------------------------------
// timed_lowest_free_allocator - lowest-free unit allocator with timed release
// A request wave runs down a chain of unit cells: first to count free units,
// then, if enough are free, to grant the lowest ones and report their sum.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  request   in_valid / in_stall / in_data    into the block
//  result    out_valid / out_stall / out_data out of the block
//  config    cfg_wen / cfg_data               into the block, unit_count
//
//  The token steps one cell per cycle along the MAX_UNITS cells: once to count for
//  every request and once more to grant for a granted one. One request is in the
//  chain at a time; the next can be taken on the edge where the result can first transfer.
//  Reset frees every unit and sets unit_count to 128.
//  A stalled result sits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module timed_lowest_free_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  tlfa_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output tlfa_pkg::out_t out_data,
	input  logic           cfg_wen,
	input  logic [7:0]     cfg_data
);
	import tlfa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [7:0]        uc_q;
	logic [CNT_W-1:0]  used;
	logic [31:0]       now_q;
	logic [7:0]        want_q;
	logic [TIME_W-1:0] expiry_q;
	logic              launch_q;
	logic              launch_grant_q;
	logic [CNT_W-1:0]  launch_cnt_q;
	out_t              res_q;
	out_t              out_q;
	logic              out_valid_q;
	logic              wave_done;
	logic              enough;
	logic              out_free;
	wave_t             wave [MAX_UNITS+1];

	assign used = (32'(uc_q) > 32'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : CNT_W'(uc_q);

	assign wave[0] = '{valid: launch_q, grant: launch_grant_q, cnt: launch_cnt_q,
		sum: '0};

	for (genvar i = 0; i < MAX_UNITS; i++) begin : g_cell
		tlfa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.now      (now_q),
			.expiry   (expiry_q),
			.used     (used),
			.wave_in  (wave[i]),
			.wave_out (wave[i+1])
		);
	end

	assign wave_done = (state_q == ST_RUN) && wave[MAX_UNITS].valid;
	assign enough    = !wave[MAX_UNITS].grant &&
		(32'(wave[MAX_UNITS].cnt) >= 32'(want_q));
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			uc_q           <= 8'd128;
			launch_q       <= 1'b0;
			launch_grant_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wen)
				uc_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					launch_q <= in_valid;
					if (in_valid) begin
						launch_grant_q <= 1'b0;
						state_q        <= ST_RUN;
					end
				end
				ST_RUN: begin
					launch_q <= wave_done && enough;
					if (wave_done) begin
						if (enough)
							launch_grant_q <= 1'b1;
						else
							state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					launch_q <= 1'b0;
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					launch_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			now_q        <= in_data.arrival_time;
			want_q       <= in_data.units_wanted;
			expiry_q     <= TIME_W'(in_data.arrival_time) + TIME_W'(in_data.hold_time);
			launch_cnt_q <= '0;
		end
		if (wave_done) begin
			if (enough) begin
				// want is at most the free count here, so it fits the counter
				launch_cnt_q <= CNT_W'(want_q);
			end else begin
				res_q.granted   <= wave[MAX_UNITS].grant;
				res_q.index_sum <= wave[MAX_UNITS].grant ? wave[MAX_UNITS].sum : '0;
			end
		end
		if (state_q == ST_DONE && out_free)
			out_q <= res_q;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/tlfa_checker.sv */
// ----------------------------------------------------------------------------
// tlfa_checker - port-level checks for the timed lowest-free allocator
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tlfa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input tlfa_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_stall,
	input tlfa_pkg::out_t out_data
);
	import tlfa_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a rejected request never reports units
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.granted |-> out_data.index_sum == '0)
		else $error("rejected request with nonzero index sum");

	// the chain takes one request at a time
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while the chain is busy");

	// the block only goes busy because of a request transfer
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("request side stalled without a transfer");

	// a request that is taken carries a known unit count
	a_in_used: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !$isunknown(in_data.units_wanted))
		else $error("unknown unit request transferred");

endmodule

bind timed_lowest_free_allocator tlfa_checker u_tlfa_checker (.*);

/* tb/tb_timed_lowest_free_allocator.sv */
// ----------------------------------------------------------------------------
// tb_timed_lowest_free_allocator - testbench for the timed lowest-free allocator
// Directed requests cover the field extremes, zero and saturated unit counts,
// same-instant release and time wrap. Random request streams then run under
// several unit counts and idle/stall mixes. An in-bench allocation model
// predicts every result, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_timed_lowest_free_allocator;

	import tlfa_pkg::*;

	localparam int QUIET_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 2 * MAX_UNITS + 10;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_t        in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_t       out_data;
	logic       cfg_wen   = 1'b0;
	logic [7:0] cfg_data  = '0;

	// allocation model state
	logic [TIME_W-1:0] unit_release [MAX_UNITS];
	logic [7:0]        unit_count_cfg;
	logic [31:0]       req_clock;

	out_t pending_grants [$];
	int   mismatches     = 0;
	int   quiet_cycles   = 0;
	int   send_idle_pct  = 0;
	int   result_stall_pct = 0;

	timed_lowest_free_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// serve the lowest free units, or reject and leave state untouched
	function automatic out_t allocate_units(in_t req);
		out_t              res;
		int                in_use;
		int                free_n;
		int                taken;
		int                sum;
		logic [TIME_W-1:0] now_t;
		now_t  = {1'b0, req.arrival_time};
		in_use = (unit_count_cfg > MAX_UNITS) ? MAX_UNITS : int'(unit_count_cfg);
		free_n = 0;
		taken  = 0;
		sum    = 0;
		for (int u = 0; u < in_use; u++)
			if (unit_release[u] <= now_t)
				free_n++;
		if (free_n < int'(req.units_wanted)) begin
			res = '0;
			return res;
		end
		for (int u = 0; u < in_use && taken < int'(req.units_wanted); u++) begin
			if (unit_release[u] <= now_t) begin
				unit_release[u] = now_t + TIME_W'(req.hold_time);
				sum += u + 1;
				taken++;
			end
		end
		res.granted   = 1'b1;
		res.index_sum = SUM_W'(sum);
		return res;
	endfunction

	// mostly rising times with short holds so units contend; some jumps,
	// late arrivals, zero or oversize requests and long holds
	function automatic in_t make_request();
		in_t req;
		int  r;
		int  cap;
		r   = $urandom_range(99);
		cap = ((unit_count_cfg > MAX_UNITS) ? MAX_UNITS : int'(unit_count_cfg)) / 4;
		if (cap < 1)
			cap = 1;
		if (r < 3) begin
			req_clock        = $urandom();
			req.arrival_time = req_clock;
		end else if (r < 6) begin
			req.arrival_time = req_clock - 32'($urandom_range(1, 500));
		end else begin
			req_clock        = req_clock + 32'($urandom_range(0, 40));
			req.arrival_time = req_clock;
		end
		r = $urandom_range(99);
		if (r < 4)
			req.units_wanted = 8'd0;
		else if (r < 8)
			req.units_wanted = 8'($urandom_range(129, 255));
		else if (r < 16)
			req.units_wanted = 8'($urandom_range(1, MAX_UNITS));
		else
			req.units_wanted = 8'($urandom_range(1, cap));
		r = $urandom_range(99);
		if (r < 5)
			req.hold_time = 16'($urandom());
		else if (r < 8)
			req.hold_time = 16'd0;
		else
			req.hold_time = 16'($urandom_range(1, 120));
		return req;
	endfunction

	// entered and left at a falling edge; valid stays up for a following request
	task automatic send_request(input in_t req);
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (in_stall);
		pending_grants.push_back(allocate_units(req));
		@(negedge clk);
	endtask

	task automatic sender_gap();
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_grants.size() != 0);
	endtask

	task automatic write_unit_count(input logic [7:0] value);
		drain_results();
		cfg_wen  <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		unit_count_cfg = value;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic test_field_extremes();
		send_request(in_t'{32'h0000_0000, 8'd0,   16'h0000});  // zero wanted
		send_request(in_t'{32'h0000_0000, 8'd1,   16'h0000});  // zero hold stays free
		send_request(in_t'{32'h0000_0000, 8'd128, 16'hFFFF});  // every unit
		send_request(in_t'{32'h0000_0000, 8'd1,   16'h0001});  // nothing free
		send_request(in_t'{32'h0000_FFFF, 8'd255, 16'h0001});  // more than exist
		send_request(in_t'{32'h0000_FFFF, 8'd128, 16'h8000});  // release at same instant
		send_request(in_t'{32'h0001_0000, 8'd64,  16'h7FFF});
		send_request(in_t'{32'h0001_7FFF, 8'd64,  16'hAAAA});
		send_request(in_t'{32'h0001_7000, 8'd1,   16'h0005});  // late arrival
		send_request(in_t'{32'h0002_0000, 8'd64,  16'h5555});
	endtask

	task automatic test_unit_count_limits();
		write_unit_count(8'd0);
		send_request(in_t'{32'h0003_0000, 8'd1, 16'h0009});
		send_request(in_t'{32'h0003_0000, 8'd0, 16'h0009});
		write_unit_count(8'd1);
		send_request(in_t'{32'h0003_0000, 8'd2, 16'h0003});
		send_request(in_t'{32'h0003_0000, 8'd1, 16'h0003});
		// saturates to the full set; units above one kept their release times
		write_unit_count(8'd255);
		send_request(in_t'{32'h0003_0000, 8'd128, 16'h0001});
		send_request(in_t'{32'h0003_0003, 8'd128, 16'h0001});
		write_unit_count(8'd128);
	endtask

	task automatic test_random_traffic(input int n_req, input int idle_pct,
			input int stall_pct, input logic [7:0] count);
		write_unit_count(count);
		send_idle_pct    = idle_pct;
		result_stall_pct = stall_pct;
		for (int i = 0; i < n_req; i++) begin
			sender_gap();
			send_request(make_request());
		end
		drain_results();
	endtask

	// release times past the 32-bit range never free again, so this goes last
	task automatic test_time_wrap();
		write_unit_count(8'd128);
		send_request(in_t'{32'hFFFF_FFFF, 8'd2,   16'hFFFF});
		send_request(in_t'{32'hFFFF_FFFF, 8'd1,   16'h0000});
		send_request(in_t'{32'hFFFF_FFFF, 8'd128, 16'h0001});
		send_request(in_t'{32'hFFFF_FFFF, 8'd1,   16'h0001});
		drain_results();
	endtask

	initial begin
		for (int u = 0; u < MAX_UNITS; u++)
			unit_release[u] = '0;
		unit_count_cfg = 8'd128;
		req_clock      = 32'h0004_0000;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_field_extremes();
		test_unit_count_limits();
		test_random_traffic(170, 0, 0, 8'd128);
		test_random_traffic(170, 48, 0, 8'($urandom_range(2, 127)));
		test_random_traffic(170, 0, 48, 8'd255);
		test_random_traffic(170, 17, 17, 8'($urandom_range(0, 255)));
		test_time_wrap();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_grants.size() != 0) begin
			$display("%0t: results outstanding expected 0 got %0d",
				$time, pending_grants.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < result_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result granted=%0d index_sum=%0d",
					$time, out_data.granted, out_data.index_sum);
				mismatches++;
			end else begin
				if (out_data.granted !== pending_grants[0].granted) begin
					$display("%0t: granted expected %0d got %0d",
						$time, pending_grants[0].granted, out_data.granted);
					mismatches++;
				end
				if (out_data.index_sum !== pending_grants[0].index_sum) begin
					$display("%0t: index_sum expected %0d got %0d",
						$time, pending_grants[0].index_sum, out_data.index_sum);
					mismatches++;
				end
				void'(pending_grants.pop_front());
			end
		end
	end

	// any transfer on either channel resets the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

/* files.f */
sv/tlfa_pkg.sv
sv/tlfa_cell.sv
sv/timed_lowest_free_allocator.sv
sv/tlfa_checker.sv
tb/tb_timed_lowest_free_allocator.sv
